### rtl/core/resistor_ladder_button_decoder_top_defines.svh
// Assertion helpers for the checker file.
`ifndef RESISTOR_LADDER_BUTTON_DECODER_TOP_DEFINES_SVH
`define RESISTOR_LADDER_BUTTON_DECODER_TOP_DEFINES_SVH

// Checked on every rising edge outside reset.
`define RLBD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rlbd assertion failed");

// Checked on every rising edge, reset included.
`define RLBD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rlbd assertion failed");

`endif

### rtl/core/rlbd_pkg.sv
package rlbd_pkg;

  localparam int unsigned SLOTS      = 4;
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned ID_W       = 8;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;

  localparam logic [MS_W-1:0]     HOLD_TIME_RST   = MS_W'(50);
  localparam logic [MS_W-1:0]     SETTLE_TIME_RST = MS_W'(200);
  localparam logic [SAMPLE_W-1:0] IDLE_THR_RST    = SAMPLE_W'(1009);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUTTON_COUNT = 3'd0,
    REG_BUTTON_IDS   = 3'd1,
    REG_CENTERS      = 3'd2,
    REG_DEVIATIONS   = 3'd3,
    REG_HOLD_TIME    = 3'd4,
    REG_SETTLE_TIME  = 3'd5,
    REG_IDLE_THR     = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [COUNT_W-1:0]       button_count;
    logic [SLOTS*ID_W-1:0]    ids;
    logic [SLOTS*SAMPLE_W-1:0] centers;
    logic [SLOTS*SAMPLE_W-1:0] deviations;
    logic [MS_W-1:0]          hold_time;
    logic [MS_W-1:0]          settle_time;
    logic [SAMPLE_W-1:0]      idle_thr;
  } cfg_t;

  typedef struct packed {
    logic clr;
    logic arm;
    logic fire;
  } slot_ctrl_t;

  typedef struct packed {
    logic hit;
    logic armed;
    logic can_fire;
  } slot_stat_t;

endpackage

### rtl/core/rlbd_in_if.sv
interface rlbd_in_if import rlbd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic [TIME_W-1:0]   now_ms;

  modport source (output valid, output sample, output now_ms, input ready);
  modport sink (input valid, input sample, input now_ms, output ready);
endinterface

### rtl/core/rlbd_out_if.sv
interface rlbd_out_if import rlbd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] pressed_id;

  modport source (output valid, output pressed_id, input ready);
  modport sink (input valid, input pressed_id, output ready);
endinterface

### rtl/core/rlbd_cfg_regs.sv
module rlbd_cfg_regs import rlbd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{button_count: '0, ids: '0, centers: '0, deviations: '0,
                 hold_time: HOLD_TIME_RST, settle_time: SETTLE_TIME_RST,
                 idle_thr: IDLE_THR_RST};
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_BUTTON_COUNT: cfg_q.button_count <= cfg_data_i[COUNT_W-1:0];
        REG_BUTTON_IDS:   cfg_q.ids          <= cfg_data_i[SLOTS*ID_W-1:0];
        REG_CENTERS:      cfg_q.centers      <= cfg_data_i[SLOTS*SAMPLE_W-1:0];
        REG_DEVIATIONS:   cfg_q.deviations   <= cfg_data_i[SLOTS*SAMPLE_W-1:0];
        REG_HOLD_TIME:    cfg_q.hold_time    <= cfg_data_i[MS_W-1:0];
        REG_SETTLE_TIME:  cfg_q.settle_time  <= cfg_data_i[MS_W-1:0];
        REG_IDLE_THR:     cfg_q.idle_thr     <= cfg_data_i[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/rlbd_slot.sv
module rlbd_slot import rlbd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                enable_i,
  input  logic [ID_W-1:0]     id_i,
  input  logic [SAMPLE_W-1:0] center_i,
  input  logic [SAMPLE_W-1:0] dev_i,
  input  logic [MS_W-1:0]     hold_time_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [TIME_W-1:0]   now_i,
  input  slot_ctrl_t          ctrl_i,
  output slot_stat_t          stat_o
);

  logic              armed_q;
  logic              reported_q;
  logic [TIME_W-1:0] start_q;

  logic [SAMPLE_W:0] sample_plus_dev;
  logic [SAMPLE_W:0] center_plus_dev;
  logic              in_window;
  logic [TIME_W-1:0] held;
  logic              ripe;

  // Strict window center - dev < sample < center + dev, rearranged so that
  // nothing goes negative.
  assign sample_plus_dev = {1'b0, sample_i} + {1'b0, dev_i};
  assign center_plus_dev = {1'b0, center_i} + {1'b0, dev_i};
  assign in_window = (sample_plus_dev > {1'b0, center_i}) &&
                     ({1'b0, sample_i} < center_plus_dev);

  assign held = now_i - start_q;
  assign ripe = held > {{(TIME_W-MS_W){1'b0}}, hold_time_i};

  assign stat_o.hit      = enable_i && (id_i != '0) && in_window;
  assign stat_o.armed    = armed_q;
  assign stat_o.can_fire = stat_o.hit && armed_q && ripe && !reported_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= 1'b0;
      reported_q <= 1'b0;
    end else if (ctrl_i.clr) begin
      armed_q    <= 1'b0;
      reported_q <= 1'b0;
    end else begin
      if (ctrl_i.arm) begin
        armed_q <= 1'b1;
      end
      if (ctrl_i.fire) begin
        reported_q <= 1'b1;
      end
    end
  end

  // The start stamp is only looked at while the slot is armed.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.arm) begin
      start_q <= now_i;
    end
  end

endmodule

### rtl/core/resistor_ladder_button_decoder_top.sv
// A result beat follows its input beat through the input register and
// then the result register.
// Throughput: one input beat per cycle; the single compute stage between the
// two registers sets this, and it stalls only while a result waits to be taken.
// Reset clears all button flags, stops the idle timer and loads the register defaults; time stamps are not reset.
module resistor_ladder_button_decoder_top import rlbd_pkg::*; #(
  parameter int unsigned MAX_BUTTONS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rlbd_in_if.sink               in_i,
  rlbd_out_if.source            out_o
);

  localparam int unsigned NumSlots = (MAX_BUTTONS < SLOTS) ? MAX_BUTTONS : SLOTS;

  cfg_t cfg;

  logic                in_valid_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [TIME_W-1:0]   now_q;

  logic                out_valid_q;
  logic [ID_W-1:0]     out_id_q;

  logic                release_timing_q, release_timing_d;
  logic [TIME_W-1:0]   release_start_q, release_start_d;
  logic                click_latch_q, click_latch_d;

  logic                stall;
  logic                go;
  logic                idle;
  logic                settled;
  logic                scan;

  slot_ctrl_t [NumSlots-1:0] ctrl;
  slot_stat_t [NumSlots-1:0] stat;
  logic [NumSlots-1:0]       arm_sel;
  logic [NumSlots-1:0]       fire_sel;
  logic                      any_fire;
  logic [ID_W-1:0]           pressed;

  rlbd_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  assign stall    = out_valid_q && !out_o.ready;
  assign go       = in_valid_q && !stall;
  assign in_i.ready = !in_valid_q || !stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      sample_q <= in_i.sample;
      now_q    <= in_i.now_ms;
    end
  end

  assign idle    = sample_q > cfg.idle_thr;
  assign settled = (now_q - release_start_q) >
                   {{(TIME_W-MS_W){1'b0}}, cfg.settle_time};
  assign scan    = go && !idle && !click_latch_q;

  for (genvar g = 0; g < NumSlots; g++) begin : g_slot
    rlbd_slot u_slot (
      .clk_i,
      .rst_ni,
      .enable_i    (cfg.button_count > COUNT_W'(g)),
      .id_i        (cfg.ids[ID_W*g +: ID_W]),
      .center_i    (cfg.centers[SAMPLE_W*g +: SAMPLE_W]),
      .dev_i       (cfg.deviations[SAMPLE_W*g +: SAMPLE_W]),
      .hold_time_i (cfg.hold_time),
      .sample_i    (sample_q),
      .now_i       (now_q),
      .ctrl_i      (ctrl[g]),
      .stat_o      (stat[g])
    );
  end

  // Table-order scan: the first slot able to fire wins and ends the scan, so
  // only slots ahead of it may arm on this sample.
  always_comb begin
    logic blocked;
    blocked  = 1'b0;
    pressed  = '0;
    for (int i = 0; i < NumSlots; i++) begin
      fire_sel[i] = stat[i].can_fire && !blocked;
      arm_sel[i]  = stat[i].hit && !stat[i].armed && !blocked;
      if (fire_sel[i]) begin
        pressed = cfg.ids[ID_W*i +: ID_W];
      end
      blocked = blocked || stat[i].can_fire;
    end
    any_fire = blocked;
  end

  always_comb begin
    for (int i = 0; i < NumSlots; i++) begin
      ctrl[i].clr  = go && idle && release_timing_q && settled;
      ctrl[i].arm  = scan && arm_sel[i];
      ctrl[i].fire = scan && fire_sel[i];
    end
  end

  always_comb begin
    release_timing_d = release_timing_q;
    release_start_d  = release_start_q;
    click_latch_d    = click_latch_q;
    if (go) begin
      if (idle && !release_timing_q) begin
        release_timing_d = 1'b1;
        release_start_d  = now_q;
      end else if (idle) begin
        if (settled) begin
          release_timing_d = 1'b0;
          click_latch_d    = 1'b0;
        end
      end else if (!click_latch_q) begin
        release_timing_d = 1'b0;
        click_latch_d    = any_fire;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      release_timing_q <= 1'b0;
      click_latch_q    <= 1'b0;
    end else begin
      release_timing_q <= release_timing_d;
      click_latch_q    <= click_latch_d;
    end
  end

  // Only read while the idle timer runs.
  always_ff @(posedge clk_i) begin
    release_start_q <= release_start_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      out_id_q <= scan ? pressed : '0;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.pressed_id = out_id_q;

endmodule

### rtl/core/rlbd_checker.sv
`include "resistor_ladder_button_decoder_top_defines.svh"

module rlbd_checker import rlbd_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [ID_W-1:0] out_id
);

  // A result beat waits until it is taken.
  `RLBD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  // A waiting result keeps its value.
  `RLBD_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_id))
  // With no result pending the input side is always open.
  `RLBD_ASSERT_ALWAYS(a_ready_when_empty, !rst_ni || out_valid || in_ready)
  // An input beat passes the input register and yields a result when the output was free.
  `RLBD_ASSERT(a_latency,
    (in_valid && in_ready) ##1 (!out_valid || out_ready) |=> out_valid)

endmodule

bind resistor_ladder_button_decoder_top rlbd_checker u_rlbd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_id    (out_o.pressed_id)
);
